>>> rtl/core/radial_brightening_pixel_top_defines.svh
// ----------------------------------------------------------------------------
// Radial brightening assertion macros
// Shared property wrappers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef RADIAL_BRIGHTENING_PIXEL_TOP_DEFINES_SVH
`define RADIAL_BRIGHTENING_PIXEL_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// Types, widths and constants shared by the radial brightening block.
// ----------------------------------------------------------------------------
package rbp_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int FRAME_W       = 13;
    localparam int COORD_W       = 12;
    localparam int RATIO_W       = 17;
    localparam int GAIN_W        = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int CHAN_W        = 8;

    localparam int DIM_LIMIT_I = (MAX_DIMENSION > 8191) ? 8191 : MAX_DIMENSION;
    localparam logic [FRAME_W-1:0] DIM_LIMIT = FRAME_W'(DIM_LIMIT_I);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int BACK_STAGES = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_ASPECT_RATIO = 2'd2,
        CFG_LIFT_GAIN    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
        logic [CHAN_W-1:0]  blue_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  red_in;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] red_out;
    } result_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } colour_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [RATIO_W-1:0] aspect_ratio_q16;
        logic [GAIN_W-1:0]  lift_gain_q32;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic               scale_x;
        colour_t            colour;
    } fe_item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

>>> rtl/core/rbp_front.sv
// ----------------------------------------------------------------------------
// rbp_front
// Accepts pixels, forms centre distances and picks the axis to scale.
// ----------------------------------------------------------------------------
module rbp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  rbp_pkg::cfg_t     cfg,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  rbp_pkg::pixel_t   pixel,
    input  logic              q_full,
    output logic              fe_valid,
    output rbp_pkg::fe_item_t fe_item
);
    import rbp_pkg::*;

    logic [FRAME_W-1:0] width_clamped;
    logic [FRAME_W-1:0] height_clamped;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               take;
    logic               fe_valid_reg;
    logic               fe_valid_next;
    fe_item_t           fe_item_reg;
    fe_item_t           fe_item_next;

    assign width_clamped  = (cfg.frame_width  > DIM_LIMIT) ? DIM_LIMIT : cfg.frame_width;
    assign height_clamped = (cfg.frame_height > DIM_LIMIT) ? DIM_LIMIT : cfg.frame_height;
    assign cx = width_clamped[FRAME_W-1:1];
    assign cy = height_clamped[FRAME_W-1:1];

    assign pixel_stall = fe_valid_reg && q_full;
    assign take        = pixel_valid && !pixel_stall;

    always_comb
    begin
        fe_item_next.dx = (cx >= pixel.pixel_col) ? cx - pixel.pixel_col
                                                  : pixel.pixel_col - cx;
        fe_item_next.dy = (cy >= pixel.pixel_row) ? cy - pixel.pixel_row
                                                  : pixel.pixel_row - cy;
        fe_item_next.scale_x      = cx > cy;
        fe_item_next.colour.blue  = pixel.blue_in;
        fe_item_next.colour.green = pixel.green_in;
        fe_item_next.colour.red   = pixel.red_in;
    end

    assign fe_valid_next = take || (fe_valid_reg && q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else
        begin
            fe_valid_reg <= fe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fe_item_reg <= fe_item_next;
        end
    end

    assign fe_valid = fe_valid_reg;
    assign fe_item  = fe_item_reg;

endmodule

>>> rtl/core/rbp_queue.sv
// ----------------------------------------------------------------------------
// rbp_queue
// Short FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module rbp_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  rbp_pkg::fe_item_t  push_item,
    input  logic               pop,
    output rbp_pkg::fe_item_t  pop_item,
    output rbp_pkg::q_status_t status
);
    import rbp_pkg::*;

    fe_item_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              do_pop;

    assign status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign status.count = count_reg;

    assign push   = push_valid && !status.full;
    assign do_pop = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = mem[rd_ptr_reg];

endmodule

>>> rtl/core/rbp_back.sv
// ----------------------------------------------------------------------------
// rbp_back
// Six-stage lift pipeline: scale, square, sum, gain, clamp, brighten.
// ----------------------------------------------------------------------------
module rbp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  rbp_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  rbp_pkg::fe_item_t q_item,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output rbp_pkg::result_t  result
);
    import rbp_pkg::*;

    localparam int LQ_W   = COORD_W + RATIO_W;
    localparam int SQ_W   = COORD_W + 16;
    localparam int SQA_W  = 2 * LQ_W;
    localparam int SQB_W  = 2 * SQ_W;
    localparam int S1_W   = ((SQA_W > SQB_W) ? SQA_W : SQB_W) + 1;
    localparam int HI_IN  = S1_W - 32;
    localparam int HI_W   = HI_IN + GAIN_W;
    localparam int LO_W   = 32 + GAIN_W;
    localparam int T_W    = HI_W + 1;
    localparam int LF_W   = T_W - 16;
    localparam int LIFT_W = 25;
    localparam int SUM_W  = LIFT_W + 1;
    localparam logic [LIFT_W-1:0] LIFT_MAX = LIFT_W'(1) << 24;

    function automatic logic [CHAN_W-1:0] brighten(input logic [CHAN_W-1:0] c,
                                                   input logic [LIFT_W-1:0] lift);
        logic [SUM_W-1:0]    sum;
        logic [SUM_W-17:0]   v;
        sum = SUM_W'({c, 16'h0000}) + SUM_W'(lift) + SUM_W'(16'h8000);
        v   = sum[SUM_W-1:16];
        return (v > (SUM_W-16)'(255)) ? CHAN_W'(255) : v[CHAN_W-1:0];
    endfunction

    logic                   en;
    logic [BACK_STAGES-1:0] valid_reg;
    colour_t                colour_reg [BACK_STAGES-1];
    logic [COORD_W-1:0]     long_d;
    logic [COORD_W-1:0]     short_d;
    logic [LQ_W-1:0]        lq_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [SQA_W-1:0]       sqa_reg;
    logic [SQB_W-1:0]       sqb_reg;
    logic [S1_W-1:0]        s1_reg;
    logic [HI_W-1:0]        hi_reg;
    logic [LO_W-1:0]        lo_prod;
    logic [31:0]            lo_top_reg;
    logic [T_W-1:0]         t_sum;
    logic [LF_W-1:0]        lift_full;
    logic [LIFT_W-1:0]      lift_reg;
    result_t                result_reg;

    assign en  = !(valid_reg[BACK_STAGES-1] && result_stall);
    assign pop = en && q_valid;

    assign long_d  = q_item.scale_x ? q_item.dx : q_item.dy;
    assign short_d = q_item.scale_x ? q_item.dy : q_item.dx;

    assign lo_prod   = LO_W'(s1_reg[31:0]) * LO_W'(cfg.lift_gain_q32);
    assign t_sum     = T_W'(hi_reg) + T_W'(lo_top_reg);
    assign lift_full = t_sum[T_W-1:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[BACK_STAGES-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lq_reg        <= LQ_W'(long_d) * LQ_W'(cfg.aspect_ratio_q16);
            sq_reg        <= {short_d, 16'h0000};
            sqa_reg       <= SQA_W'(lq_reg) * SQA_W'(lq_reg);
            sqb_reg       <= SQB_W'(sq_reg) * SQB_W'(sq_reg);
            s1_reg        <= S1_W'(sqa_reg) + S1_W'(sqb_reg);
            hi_reg        <= HI_W'(s1_reg[S1_W-1:32]) * HI_W'(cfg.lift_gain_q32);
            lo_top_reg    <= lo_prod[LO_W-1:32];
            lift_reg      <= (lift_full > LF_W'(LIFT_MAX)) ? LIFT_MAX
                                                           : lift_full[LIFT_W-1:0];
            colour_reg[0] <= q_item.colour;
            for (int i = 1; i < BACK_STAGES - 1; i++)
            begin
                colour_reg[i] <= colour_reg[i-1];
            end
            result_reg.blue_out  <= brighten(colour_reg[BACK_STAGES-2].blue,  lift_reg);
            result_reg.green_out <= brighten(colour_reg[BACK_STAGES-2].green, lift_reg);
            result_reg.red_out   <= brighten(colour_reg[BACK_STAGES-2].red,   lift_reg);
        end
    end

    assign result_valid = valid_reg[BACK_STAGES-1];
    assign result       = result_reg;

endmodule

>>> rtl/core/radial_brightening_pixel_top.sv
// ----------------------------------------------------------------------------
// Radial brightening pixel top
// Adds a radial lift, growing with distance from the frame centre, to BGR.
// ----------------------------------------------------------------------------
// Pixel channel: pixel_valid / pixel_stall / pixel carry column, row and BGR.
// Result channel: result_valid / result_stall / result carry the three
// brightened channels, one item per pixel, in order.
// Configuration: cfg_write_en, cfg_index, cfg_data write frame width, frame
// height, aspect ratio (Q1.16) and lift gain (Q0.32); write only when idle.
// Throughput: one item per clock while result_stall is low, set by the fully
// pipelined back end; no unit is shared between items.
// Path from pixel acceptance to result valid: one front register, the
// four-entry queue, then six back stages (scale, square, sum, gain
// products, lift clamp, brighten).
// Reset clears all valid state and loads the register defaults
// (640 x 480, ratio 0.75, gain for that frame).
// A stalled result freezes the back stages; the queue then fills and
// pixel_stall rises once the front register is also held.
// ----------------------------------------------------------------------------
`include "radial_brightening_pixel_top_defines.svh"

module radial_brightening_pixel_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  rbp_pkg::pixel_t                  pixel,
    output logic                             result_valid,
    input  logic                             result_stall,
    output rbp_pkg::result_t                 result,
    input  logic                             cfg_write_en,
    input  logic [rbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rbp_pkg::*;

    cfg_t      cfg_reg;
    logic      fe_valid;
    fe_item_t  fe_item;
    fe_item_t  q_item;
    q_status_t q_status;
    logic      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width      <= FRAME_W'(640);
            cfg_reg.frame_height     <= FRAME_W'(480);
            cfg_reg.aspect_ratio_q16 <= RATIO_W'(49152);
            cfg_reg.lift_gain_q32    <= GAIN_W'(13690208);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width      <= cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height     <= cfg_data[FRAME_W-1:0];
                CFG_ASPECT_RATIO: cfg_reg.aspect_ratio_q16 <= cfg_data[RATIO_W-1:0];
                CFG_LIFT_GAIN:    cfg_reg.lift_gain_q32    <= cfg_data[GAIN_W-1:0];
                default:          cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    rbp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .q_full      (q_status.full),
        .fe_valid    (fe_valid),
        .fe_item     (fe_item)
    );

    rbp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_item  (fe_item),
        .pop        (pop),
        .pop_item   (q_item),
        .status     (q_status)
    );

    rbp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (!q_status.empty),
        .q_item       (q_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `RBP_ASSERT_NEXT(a_take_held, clk, rst_n, pixel_valid && !pixel_stall, fe_valid, "accepted item missing from front register")
    `RBP_ASSERT_NEXT(a_front_hold, clk, rst_n, fe_valid && q_status.full, fe_valid && $stable(fe_item), "front item lost while queue full")
    `RBP_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, q_status.count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule
